// File: hw/rtl/scr_pkg.sv
`default_nettype none

package scr_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN = 26;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);
  localparam int unsigned SUM_W     = 13;

  localparam logic [POS_W-1:0] POS_HDR0    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CMD_LO  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_CMD_HI  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_VAL_LO  = POS_W'(10);
  localparam logic [POS_W-1:0] POS_VAL_HI  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_CKS_LO  = POS_W'(FRAME_LEN - 2);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_LEN - 1);

  localparam logic [7:0] HDR0_BYTE  = 8'hAA;
  localparam logic [7:0] HDR1_BYTE  = 8'h55;
  localparam logic [7:0] FLAG_TAKEN = 8'h01;

  // command codes
  localparam logic [15:0] CMD_STATUS     = 16'h0046;
  localparam logic [15:0] CMD_IMAGE      = 16'h0020;
  localparam logic [15:0] CMD_GENERATE_T = 16'h0060;
  localparam logic [15:0] CMD_STORE      = 16'h0040;
  localparam logic [15:0] CMD_MERGE_T    = 16'h0061;
  localparam logic [15:0] CMD_SEARCH_T   = 16'h0063;

  // frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_BAD_SUM = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // everything gathered over bytes 0 to 24
  typedef struct packed {
    logic             hdr_match;
    logic [SUM_W-1:0] sum;
    logic [15:0]      cmd;
    logic [15:0]      value;
    logic [7:0]       cks_lo;
  } frame_t;

  typedef struct packed {
    logic [15:0] reply_value;
    logic [15:0] command_word;
    logic        header_ok;
    logic        checksum_ok;
    logic [1:0]  frame_status;
  } reply_t;

endpackage

`default_nettype wire

// File: hw/rtl/scr_frame_acc.sv
`default_nettype none

module scr_frame_acc
  import scr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output frame_t          frame,
  output logic            last
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  frame_t           frm_r, frm_nxt;

  assign last  = (pos_r >= POS_LAST);
  assign frame = frm_r;

  always_comb begin
    pos_nxt = pos_r;
    frm_nxt = frm_r;
    if (accept) begin
      if (last) begin
        pos_nxt = '0;
        frm_nxt = '{hdr_match: 1'b1, default: '0};
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r < POS_CKS_LO) begin
          frm_nxt.sum = frm_r.sum + SUM_W'(rx_byte);
        end
        case (pos_r)
          POS_HDR0:   frm_nxt.hdr_match = (rx_byte == HDR0_BYTE);
          POS_HDR1:   frm_nxt.hdr_match = frm_r.hdr_match & (rx_byte == HDR1_BYTE);
          POS_CMD_LO: frm_nxt.cmd[7:0]    = rx_byte;
          POS_CMD_HI: frm_nxt.cmd[15:8]   = rx_byte;
          POS_VAL_LO: frm_nxt.value[7:0]  = rx_byte;
          POS_VAL_HI: frm_nxt.value[15:8] = rx_byte;
          POS_CKS_LO: frm_nxt.cks_lo      = rx_byte;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      frm_r <= '{hdr_match: 1'b1, default: '0};
    end else begin
      pos_r <= pos_nxt;
      frm_r <= frm_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scr_decode.sv
`default_nettype none

module scr_decode
  import scr_pkg::*;
(
  input  wire frame_t     frame,
  input  wire logic [7:0] cks_hi,
  output reply_t          reply
);

  logic [15:0] recv_sum;
  logic        sum_ok;

  assign recv_sum = {cks_hi, frame.cks_lo};
  assign sum_ok   = ({{(16 - SUM_W){1'b0}}, frame.sum} == recv_sum);

  always_comb begin
    reply.command_word = frame.cmd;
    reply.header_ok    = frame.hdr_match;
    reply.checksum_ok  = sum_ok;
    reply.reply_value  = '0;
    reply.frame_status = ST_OK;
    if (!frame.hdr_match) begin
      reply.frame_status = ST_BAD_HDR;
    end else if (!sum_ok) begin
      reply.frame_status = ST_BAD_SUM;
    end else begin
      unique case (frame.cmd) inside
        CMD_STATUS: begin
          reply.reply_value = (frame.value[7:0] == FLAG_TAKEN) ? 16'd0 : 16'd1;
        end
        CMD_IMAGE, CMD_GENERATE_T, CMD_STORE, CMD_MERGE_T: begin
          reply.reply_value = 16'd1;
        end
        CMD_SEARCH_T: begin
          reply.reply_value = frame.value;
        end
        default: begin
          reply.frame_status = ST_UNKNOWN;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sensor_reply_frame_checker.sv
`default_nettype none

// sensor reply frame checker
// takes received serial bytes, one request per byte, and groups them into
// fixed 26-byte reply frames counted from reset (no resynchronisation: the
// first byte after reset is byte 0 of a frame). bytes 0 and 1 must be aa 55,
// bytes 4/5 carry the command word, bytes 10/11 the value word and bytes
// 24/25 the little-endian sum of bytes 0 to 23. a byte is taken whenever it is
// not stalled, so bytes may arrive back to back. on byte 25 one result request is
// loaded into the output register and shown from the next cycle: header and
// checksum verdicts, command word, status (0 known command, 1 bad header,
// 2 bad checksum, 3 unknown command) and the reply value (0/1 flag, or the
// matched id for a search). bytes 0 to 24 are never stalled; byte 25 is held
// off only while the previous result is still waiting at a stalled output.

module sensor_reply_frame_checker
  import scr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_reply_value,
  output logic [15:0]      out_command_word,
  output logic             out_header_ok,
  output logic             out_checksum_ok,
  output logic [1:0]       out_frame_status
);

  logic   in_accept;
  logic   last;
  frame_t frame;
  reply_t reply;

  logic   out_valid_r, out_valid_nxt;
  reply_t out_r;

  // the last byte needs room in the output register, the others never do
  assign in_stall  = last & out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // per-byte capture of position, sum, header flag and fields
  scr_frame_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_rx_byte),
    .frame   (frame),
    .last    (last)
  );

  // verdicts and reply from the captured frame and the final byte
  scr_decode u_dec (
    .frame  (frame),
    .cks_hi (in_rx_byte),
    .reply  (reply)
  );

  // result register: loaded on the last byte, held while stalled
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_accept && last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_accept && last) begin
      out_r <= reply;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reply_value  = out_r.reply_value;
  assign out_command_word = out_r.command_word;
  assign out_header_ok    = out_r.header_ok;
  assign out_checksum_ok  = out_r.checksum_ok;
  assign out_frame_status = out_r.frame_status;

endmodule

`default_nettype wire

// File: hw/rtl/scr_checker.sv
`default_nettype none

module scr_checker
  import scr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_rx_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_reply_value,
  input wire logic [15:0] out_command_word,
  input wire logic        out_header_ok,
  input wire logic        out_checksum_ok,
  input wire logic [1:0]  out_frame_status
);

  // a stalled byte stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("byte changed while stalled");

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reply_value)
      && $stable(out_command_word) && $stable(out_frame_status)
      && $stable(out_header_ok) && $stable(out_checksum_ok))
    else $error("result changed while stalled");

  // a new result only follows an accepted byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without a received byte");

  // status agrees with the verdicts
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_frame_status == ST_BAD_HDR) == !out_header_ok)
      && ((out_frame_status == ST_BAD_SUM) == (out_header_ok && !out_checksum_ok)))
    else $error("status disagrees with verdicts");

  // failed or unknown frames carry no reply
  a_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status != ST_OK) |-> out_reply_value == 16'd0)
    else $error("reply value on a failed frame");

endmodule

bind sensor_reply_frame_checker scr_checker u_scr_checker (.*);

`default_nettype wire
